@@ sv/jshd_pkg.sv @@
// ----------------------------------------------------------------------------
// jshd_pkg
// Shared widths, codes and types for the joint stillness hold detector.
// ----------------------------------------------------------------------------
`default_nettype none

package jshd_pkg;

	// Field widths
	localparam int POS_W     = 20;
	localparam int POS_COUNT = 8;
	localparam int STAMP_W   = 40;
	localparam int GAP_W     = STAMP_W + 1;
	localparam int THR_W     = 20;
	localparam int LIM_W     = 32;
	localparam int DELTA_W   = POS_W + 1;
	localparam int USEC_W    = 20;
	localparam int LHS_W     = DELTA_W + USEC_W;
	localparam int RHS_W     = THR_W + LIM_W;
	localparam int MODE_W    = 2;
	localparam int EVENT_W   = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	// Microseconds per second
	localparam logic [USEC_W-1:0] US_PER_S = 20'd1000000;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GOAL    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PREEMPT = 2'd2;

	// Result events
	localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EVENT_W-1:0] EV_STILL   = 3'd1;
	localparam logic [EVENT_W-1:0] EV_RESUME  = 3'd2;
	localparam logic [EVENT_W-1:0] EV_POSE    = 3'd3;
	localparam logic [EVENT_W-1:0] EV_GOAL    = 3'd4;
	localparam logic [EVENT_W-1:0] EV_PREEMPT = 3'd5;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 2'd2;

	// Register reset values
	localparam logic [THR_W-1:0] SPEED_RST = 20'd49152;
	localparam logic [LIM_W-1:0] GAP_RST   = 32'd1000000;
	localparam logic [LIM_W-1:0] HOLD_RST  = 32'd1500000;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [POS_COUNT-1:0][POS_W-1:0] pos_vec_t;

	// Per-stage advance enables
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en_out;
	} pipe_en_t;

	// Item as it reaches the merge stage
	typedef struct packed {
		logic               valid;
		logic [MODE_W-1:0]  mode;
		logic [STAMP_W-1:0] stamp;
		logic               gap_lt;
	} ctrl_item_t;

endpackage

`default_nettype wire

@@ sv/jshd_lane.sv @@
// ----------------------------------------------------------------------------
// jshd_lane
// One joint's motion test: |delta| * 1e6 against threshold * gap, pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module jshd_lane
	import jshd_pkg::*;
(
	input  wire logic             clk,
	input  wire pipe_en_t         en,
	input  wire pos_t             pos,
	input  wire pos_t             prev_pos,
	input  wire logic [RHS_W-1:0] rhs_s2,
	output logic                  mov_s3
);

	logic signed [DELTA_W-1:0] delta;
	logic [DELTA_W-1:0]        abs_delta;
	logic [DELTA_W-1:0]        ad_s1;
	logic [LHS_W-1:0]          lhs_s2;

	// Position change and magnitude; 21 bits hold both
	always_comb begin
		delta     = DELTA_W'(pos) - DELTA_W'(prev_pos);
		abs_delta = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
	end

	always_ff @(posedge clk) begin
		if (en.en1) begin
			ad_s1 <= abs_delta;
		end
		if (en.en2) begin
			lhs_s2 <= LHS_W'(ad_s1) * LHS_W'(US_PER_S);
		end
		if (en.en3) begin
			mov_s3 <= RHS_W'(lhs_s2) > rhs_s2;
		end
	end

endmodule

`default_nettype wire

@@ sv/jshd_ctrl.sv @@
// ----------------------------------------------------------------------------
// jshd_ctrl
// Merges lane results and runs the moving / goal / hold state per item.
// ----------------------------------------------------------------------------
`default_nettype none

module jshd_ctrl
	import jshd_pkg::*;
#(
	parameter int NUM_JOINTS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pipe_en_t              en,
	input  wire ctrl_item_t            item,
	input  wire logic [NUM_JOINTS-1:0] lane_mov,
	input  wire pos_vec_t              pos_s3,
	input  wire logic [LIM_W-1:0]      hold_limit,
	output logic                       out_valid,
	output logic [EVENT_W-1:0]         event_q,
	output logic                       is_moving_q,
	output logic                       goal_on_q,
	output pos_vec_t                   out_pos_q
);

	logic               moving_q;
	logic               goal_q;
	logic [STAMP_W-1:0] hold_start_q;

	logic               any_mov;
	logic               mf_nx;
	logic               ga_nx;
	logic [STAMP_W-1:0] hs_nx;
	logic [EVENT_W-1:0] ev_nx;
	logic               report;
	logic [GAP_W-1:0]   held;
	logic               held_gt;

	// Merge: any tested joint moving
	assign any_mov = |lane_mov;

	// Time held since stillness began, against the stored start
	assign held    = GAP_W'(item.stamp) - GAP_W'(hold_start_q);
	assign held_gt = $signed(held) > $signed(GAP_W'(hold_limit));

	// Next state for the item at the head of the merge stage
	always_comb begin
		mf_nx  = moving_q;
		ga_nx  = goal_q;
		hs_nx  = hold_start_q;
		ev_nx  = EV_NONE;
		report = 1'b0;
		unique case (item.mode)
			MODE_GOAL: begin
				ga_nx = 1'b1;
				ev_nx = EV_GOAL;
			end
			MODE_PREEMPT: begin
				ga_nx = 1'b0;
				ev_nx = EV_PREEMPT;
			end
			MODE_SAMPLE: begin
				if (item.gap_lt) begin
					if (!any_mov && moving_q && goal_q) begin
						hs_nx = item.stamp;
						mf_nx = 1'b0;
						ev_nx = EV_STILL;
					end else if (!moving_q && any_mov) begin
						hs_nx = item.stamp;
						mf_nx = 1'b1;
						ev_nx = EV_RESUME;
					end
				end else begin
					mf_nx = 1'b1;
				end
				// A hold that just began has zero length, so only an old start counts
				if (!mf_nx && goal_q && ev_nx != EV_STILL && held_gt) begin
					ev_nx  = EV_POSE;
					report = 1'b1;
					ga_nx  = 1'b0;
					mf_nx  = 1'b1;
				end
			end
			default: begin
				ev_nx = EV_NONE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q     <= 1'b1;
			goal_q       <= 1'b0;
			hold_start_q <= '0;
			out_valid    <= 1'b0;
		end else if (en.en_out) begin
			out_valid <= item.valid;
			if (item.valid) begin
				moving_q     <= mf_nx;
				goal_q       <= ga_nx;
				hold_start_q <= hs_nx;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (en.en_out && item.valid) begin
			event_q     <= ev_nx;
			is_moving_q <= mf_nx;
			goal_on_q   <= ga_nx;
			out_pos_q   <= report ? pos_s3 : '0;
		end
	end

endmodule

`default_nettype wire

@@ sv/joint_stillness_hold_detector.sv @@
// ----------------------------------------------------------------------------
// joint_stillness_hold_detector
// Flags arm stillness from timestamped joint samples and reports the pose
// once a goal has been held still past the hold limit.
// ----------------------------------------------------------------------------
// One transaction per clock in and out while nothing stalls, one result per
// input item, which passes the delta, multiply and compare registers and then
// the output register. The rate is set by the per-joint lanes (delta, multiply,
// compare stages) running side by side, and by the state update in the merge
// stage, which lets each item see the flags left by the one before it. A result
// waits in the output register while stages behind it keep filling; in_stall
// rises only when every stage holds an item and out_stall is high.
`default_nettype none

module joint_stillness_hold_detector
	import jshd_pkg::*;
#(
	parameter int NUM_JOINTS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [MODE_W-1:0]     mode,
	input  wire logic [STAMP_W-1:0]    stamp_us,
	input  wire pos_t                  pos_0,
	input  wire pos_t                  pos_1,
	input  wire pos_t                  pos_2,
	input  wire pos_t                  pos_3,
	input  wire pos_t                  pos_4,
	input  wire pos_t                  pos_5,
	input  wire pos_t                  pos_6,
	input  wire pos_t                  pos_7,
	// output channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [EVENT_W-1:0]         event_res,
	output logic                       is_moving,
	output logic                       goal_on,
	output pos_t                       out_pos_0,
	output pos_t                       out_pos_1,
	output pos_t                       out_pos_2,
	output pos_t                       out_pos_3,
	output pos_t                       out_pos_4,
	output pos_t                       out_pos_5,
	output pos_t                       out_pos_6,
	output pos_t                       out_pos_7
);

	logic [THR_W-1:0]   speed_thr_q;
	logic [LIM_W-1:0]   gap_limit_q;
	logic [LIM_W-1:0]   hold_limit_q;

	pos_vec_t           in_pos;
	pos_vec_t           prev_pos_q;
	logic [STAMP_W-1:0] prev_stamp_q;
	logic               in_accept;

	pipe_en_t           pipe_en;
	logic               v1_q;
	logic               v2_q;
	logic               v3_q;

	logic [MODE_W-1:0]  mode_s1;
	logic [STAMP_W-1:0] stamp_s1;
	logic [GAP_W-1:0]   gap_s1;
	pos_vec_t           pos_s1;

	logic [MODE_W-1:0]  mode_s2;
	logic [STAMP_W-1:0] stamp_s2;
	logic               gap_lt_s2;
	logic [RHS_W-1:0]   rhs_s2;
	pos_vec_t           pos_s2;

	logic [MODE_W-1:0]  mode_s3;
	logic [STAMP_W-1:0] stamp_s3;
	logic               gap_lt_s3;
	pos_vec_t           pos_s3;

	logic [NUM_JOINTS-1:0] lane_mov_s3;
	ctrl_item_t         item_s3;
	pos_vec_t           out_pos;

	assign in_pos[0] = pos_0;
	assign in_pos[1] = pos_1;
	assign in_pos[2] = pos_2;
	assign in_pos[3] = pos_3;
	assign in_pos[4] = pos_4;
	assign in_pos[5] = pos_5;
	assign in_pos[6] = pos_6;
	assign in_pos[7] = pos_7;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_thr_q  <= SPEED_RST;
			gap_limit_q  <= GAP_RST;
			hold_limit_q <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SPEED: speed_thr_q  <= cfg_data[THR_W-1:0];
				CFG_GAP:   gap_limit_q  <= cfg_data[LIM_W-1:0];
				CFG_HOLD:  hold_limit_q <= cfg_data[LIM_W-1:0];
				default:   ;
			endcase
		end
	end

	// Stage enables: a stage advances when empty or when the next one advances
	always_comb begin
		pipe_en.en_out = !out_valid || !out_stall;
		pipe_en.en3    = !v3_q || pipe_en.en_out;
		pipe_en.en2    = !v2_q || pipe_en.en3;
		pipe_en.en1    = !v1_q || pipe_en.en2;
	end

	assign in_stall  = !pipe_en.en1;
	assign in_accept = in_valid && !in_stall;

	// Previous sample, updated on each accepted joint sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q   <= '0;
			prev_stamp_q <= '0;
		end else if (in_accept && mode == MODE_SAMPLE) begin
			prev_pos_q   <= in_pos;
			prev_stamp_q <= stamp_us;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (pipe_en.en1) begin
				v1_q <= in_valid;
			end
			if (pipe_en.en2) begin
				v2_q <= v1_q;
			end
			if (pipe_en.en3) begin
				v3_q <= v2_q;
			end
		end
	end

	// Stage 1: signed sample gap
	always_ff @(posedge clk) begin
		if (pipe_en.en1) begin
			mode_s1  <= mode;
			stamp_s1 <= stamp_us;
			gap_s1   <= GAP_W'(stamp_us) - GAP_W'(prev_stamp_q);
			pos_s1   <= in_pos;
		end
	end

	// Stage 2: gap limit test and threshold * gap.
	// A negative gap takes an all-ones bound that no |delta| * 1e6 can pass.
	always_ff @(posedge clk) begin
		if (pipe_en.en2) begin
			mode_s2   <= mode_s1;
			stamp_s2  <= stamp_s1;
			pos_s2    <= pos_s1;
			gap_lt_s2 <= $signed(gap_s1) < $signed(GAP_W'(gap_limit_q));
			rhs_s2    <= gap_s1[GAP_W-1] ? '1 :
			             RHS_W'(speed_thr_q) * RHS_W'(gap_s1[LIM_W-1:0]);
		end
	end

	// Stage 3: lane compares land here
	always_ff @(posedge clk) begin
		if (pipe_en.en3) begin
			mode_s3   <= mode_s2;
			stamp_s3  <= stamp_s2;
			gap_lt_s3 <= gap_lt_s2;
			pos_s3    <= pos_s2;
		end
	end

	// Per-joint motion lanes; joints past NUM_JOINTS are carried, not tested
	for (genvar g = 0; g < NUM_JOINTS; g++) begin : g_lane
		jshd_lane u_lane (
			.clk      (clk),
			.en       (pipe_en),
			.pos      (in_pos[g]),
			.prev_pos (prev_pos_q[g]),
			.rhs_s2   (rhs_s2),
			.mov_s3   (lane_mov_s3[g])
		);
	end

	always_comb begin
		item_s3.valid  = v3_q;
		item_s3.mode   = mode_s3;
		item_s3.stamp  = stamp_s3;
		item_s3.gap_lt = gap_lt_s3;
	end

	// Merge and state update
	jshd_ctrl #(
		.NUM_JOINTS (NUM_JOINTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (pipe_en),
		.item        (item_s3),
		.lane_mov    (lane_mov_s3),
		.pos_s3      (pos_s3),
		.hold_limit  (hold_limit_q),
		.out_valid   (out_valid),
		.event_q     (event_res),
		.is_moving_q (is_moving),
		.goal_on_q   (goal_on),
		.out_pos_q   (out_pos)
	);

	assign out_pos_0 = out_pos[0];
	assign out_pos_1 = out_pos[1];
	assign out_pos_2 = out_pos[2];
	assign out_pos_3 = out_pos[3];
	assign out_pos_4 = out_pos[4];
	assign out_pos_5 = out_pos[5];
	assign out_pos_6 = out_pos[6];
	assign out_pos_7 = out_pos[7];

endmodule

`default_nettype wire

@@ sv/jshd_checker.sv @@
// ----------------------------------------------------------------------------
// jshd_checker
// Port-level checks on result transactions of the hold detector.
// ----------------------------------------------------------------------------
`default_nettype none

module jshd_checker
	import jshd_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [EVENT_W-1:0] event_res,
	input wire logic               is_moving,
	input wire logic               goal_on,
	input wire pos_t               out_pos_0
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res))
		else $error("stalled result changed");

	// Pose report ends the goal and rearms motion
	a_pose_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_POSE |-> !goal_on && is_moving)
		else $error("pose report with wrong flags");

	// Stillness only begins under an active goal
	a_still_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_STILL |-> goal_on && !is_moving)
		else $error("still event with wrong flags");

	// Goal events set the goal flag accordingly
	a_goal_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_GOAL || event_res == EV_PREEMPT)
		|-> goal_on == (event_res == EV_GOAL))
		else $error("goal flag disagrees with event");

	// Joint 0's pose field is zero unless a pose is reported
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_POSE |-> out_pos_0 == '0)
		else $error("pose field set without report");

endmodule

bind joint_stillness_hold_detector jshd_checker u_jshd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.event_res (event_res),
	.is_moving (is_moving),
	.goal_on   (goal_on),
	.out_pos_0 (out_pos_0)
);

`default_nettype wire

@@ verif/joint_stillness_hold_detector_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joint_stillness_hold_detector_tb
// Self-checking bench for the joint stillness hold detector.
// ----------------------------------------------------------------------------
// A stimulus table covers the mode codes, timestamp and position extremes,
// zero, negative and oversized gaps, the threshold boundary and a full hold
// ending in a pose report. Random phases then follow under several register
// settings. Every accepted input transaction is run through a behavioral
// predictor, and each output transaction is compared field by field with
// the oldest expected result, the table's own where a row gives one.
// ----------------------------------------------------------------------------

module joint_stillness_hold_detector_tb;
	import jshd_pkg::*;

	localparam int          JOINTS_TESTED   = 8;
	localparam int          N_PHASES        = 7;
	localparam int          ITEMS_PER_PHASE = 200;
	localparam int          CALM_ITEMS      = 100;
	localparam int          HOLD_OFF_CYC    = 48;
	localparam int          DRAIN_CYC       = 8;
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int          NO_JOINT        = -1;
	localparam longint      USEC_PER_SEC    = 1000000;

	// Mode code and register index left unused by the block
	localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE    = 2'd3;

	localparam pos_t POS_MAX = 20'sd524287;
	localparam pos_t POS_MIN = -20'sd524288;

	typedef struct packed {
		logic [MODE_W-1:0]  md;
		logic [STAMP_W-1:0] stamp;
		pos_vec_t           pos;
	} joint_item_t;

	typedef struct packed {
		logic [EVENT_W-1:0] ev;
		logic               mv;
		logic               gl;
		pos_vec_t           pos;
	} hold_res_t;

	typedef struct packed {
		joint_item_t it;
		logic        typed;
		hold_res_t   want;
	} dir_row_t;

	// DUT connections
	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [MODE_W-1:0]    mode;
	logic [STAMP_W-1:0]   stamp_us;
	pos_vec_t             in_pos;
	logic                 out_valid;
	logic                 out_stall;
	logic [EVENT_W-1:0]   event_res;
	logic                 is_moving;
	logic                 goal_on;
	pos_t                 out_pos_0, out_pos_1, out_pos_2, out_pos_3;
	pos_t                 out_pos_4, out_pos_5, out_pos_6, out_pos_7;

	// Predictor state and register copies
	pos_vec_t           last_pos;
	logic [STAMP_W-1:0] last_stamp;
	logic               arm_moving;
	logic               goal_live;
	logic [STAMP_W-1:0] still_since;
	logic [THR_W-1:0]   thr_q;
	logic [LIM_W-1:0]   gap_lim_q;
	logic [LIM_W-1:0]   hold_lim_q;

	hold_res_t   pending_res[$];
	dir_row_t    dir_rows[$];
	int          n_err   = 0;
	int          n_items = 0;
	int          n_res   = 0;
	int          n_poses = 0;
	int          n_cfg   = 0;
	int unsigned cyc     = 0;
	logic        calm     = 1'b0;
	logic        hold_req = 1'b0;

	joint_stillness_hold_detector #(
		.NUM_JOINTS(JOINTS_TESTED)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.stamp_us  (stamp_us),
		.pos_0     (in_pos[0]),
		.pos_1     (in_pos[1]),
		.pos_2     (in_pos[2]),
		.pos_3     (in_pos[3]),
		.pos_4     (in_pos[4]),
		.pos_5     (in_pos[5]),
		.pos_6     (in_pos[6]),
		.pos_7     (in_pos[7]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_res (event_res),
		.is_moving (is_moving),
		.goal_on   (goal_on),
		.out_pos_0 (out_pos_0),
		.out_pos_1 (out_pos_1),
		.out_pos_2 (out_pos_2),
		.out_pos_3 (out_pos_3),
		.out_pos_4 (out_pos_4),
		.out_pos_5 (out_pos_5),
		.out_pos_6 (out_pos_6),
		.out_pos_7 (out_pos_7)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Run limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cyc,
				pending_res.size());
			$display("FAIL joint_stillness_hold_detector");
			$finish;
		end
	end

	// Stillness/hold predictor: one result per transaction
	function automatic hold_res_t predict_hold(joint_item_t it);
		hold_res_t r;
		longint    gap, held, lim, rhs, mag, now_p, old_p;
		logic      moved, report;
		r = '0;
		report = 1'b0;
		case (it.md)
			MODE_GOAL: begin
				goal_live = 1'b1;
				r.ev = EV_GOAL;
			end
			MODE_PREEMPT: begin
				goal_live = 1'b0;
				r.ev = EV_PREEMPT;
			end
			MODE_SAMPLE: begin
				gap = it.stamp;
				old_p = last_stamp;
				gap = gap - old_p;
				lim = gap_lim_q;
				if (gap < lim) begin
					moved = 1'b0;
					// time going backwards leaves every joint still
					if (gap >= 0) begin
						rhs = thr_q;
						rhs = rhs * gap;
						for (int i = 0; i < JOINTS_TESTED; i++) begin
							now_p = pos_t'(it.pos[i]);
							old_p = pos_t'(last_pos[i]);
							mag = now_p - old_p;
							if (mag < 0)
								mag = -mag;
							if (mag * USEC_PER_SEC > rhs)
								moved = 1'b1;
						end
					end
					if (!moved && arm_moving && goal_live) begin
						still_since = it.stamp;
						arm_moving = 1'b0;
						r.ev = EV_STILL;
					end else if (!arm_moving && moved) begin
						still_since = it.stamp;
						arm_moving = 1'b1;
						r.ev = EV_RESUME;
					end
				end else begin
					arm_moving = 1'b1;
				end
				// held long enough with a goal active: report the pose
				if (!arm_moving && goal_live) begin
					held = it.stamp;
					old_p = still_since;
					held = held - old_p;
					lim = hold_lim_q;
					if (held > lim) begin
						r.ev = EV_POSE;
						report = 1'b1;
						goal_live = 1'b0;
						arm_moving = 1'b1;
					end
				end
				last_pos = it.pos;
				last_stamp = it.stamp;
			end
			default: ;
		endcase
		r.mv = arm_moving;
		r.gl = goal_live;
		if (report)
			r.pos = it.pos;
		return r;
	endfunction

	// Stimulus table entry; positions all at base, optionally one joint at jv
	function automatic void add_row(logic [MODE_W-1:0] md, logic [STAMP_W-1:0] st,
			pos_t base, int j, pos_t jv, logic typed, logic [EVENT_W-1:0] ev,
			logic mv, logic gl);
		dir_row_t row;
		row = '0;
		row.it.md = md;
		row.it.stamp = st;
		for (int i = 0; i < POS_COUNT; i++)
			row.it.pos[i] = base;
		if (j >= 0)
			row.it.pos[j] = jv;
		row.typed = typed;
		row.want.ev = ev;
		row.want.mv = mv;
		row.want.gl = gl;
		dir_rows.push_back(row);
	endfunction

	// Random transaction: mostly plausible sample streams around the limits
	function automatic joint_item_t next_item();
		joint_item_t it;
		int          r, j;
		longint      step, lim, span, dv, pv;
		it.md = MODE_SAMPLE;
		it.stamp = last_stamp;
		it.pos = last_pos;
		lim = gap_lim_q;
		r = $urandom_range(0, 99);
		if (r < 7) begin
			it.md = MODE_GOAL;
		end else if (r < 10) begin
			it.md = MODE_PREEMPT;
		end else if (r < 16) begin
			// noise: unused or sample mode, any stamp, any pose
			it.md = (r < 12) ? MODE_UNUSED : MODE_SAMPLE;
			it.stamp = {8'($urandom), 32'($urandom)};
			for (int i = 0; i < POS_COUNT; i++)
				it.pos[i] = 20'($urandom);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				step = $urandom_range(1, 5000);
				step = -step;
			end else if (r < 16 || lim == 0) begin
				step = lim + $urandom_range(0, 1000);
			end else if (r < 58 && lim >= 2) begin
				step = $urandom_range(32'(lim / 2), 32'(lim - 1));
			end else begin
				step = $urandom_range(0, 32'(lim - 1));
			end
			it.stamp = last_stamp + step[STAMP_W-1:0];
			j = $urandom_range(0, POS_COUNT - 1);
			if ($urandom_range(0, 99) < 65) begin
				// jitter that stays under the speed threshold
				span = 0;
				if (step > 0) begin
					span = thr_q;
					span = span * step / USEC_PER_SEC;
					if (span > 1000)
						span = 1000;
				end
				dv = $urandom_range(0, 32'(2 * span));
				dv = dv - span;
				pv = pos_t'(it.pos[j]);
				pv = pv + dv;
				it.pos[j] = pv[POS_W-1:0];
			end else begin
				it.pos[j] = 20'($urandom);
			end
		end
		return it;
	endfunction

	// Offer one transaction, wait for it to be taken, record its result
	task automatic send_item(joint_item_t it, logic typed, hold_res_t want);
		hold_res_t pred;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.md;
		stamp_us <= it.stamp;
		in_pos <= it.pos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = predict_hold(it);
		pending_res.push_back(typed ? want : pred);
		n_items++;
	endtask

	// Write all registers, plus one write to an unused index
	task automatic load_regs(logic [THR_W-1:0] thr, logic [LIM_W-1:0] gl,
			logic [LIM_W-1:0] hl);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SPEED;
		cfg_data <= {12'($urandom), thr};
		@(posedge clk);
		cfg_index <= CFG_GAP;
		cfg_data <= gl;
		@(posedge clk);
		cfg_index <= CFG_HOLD;
		cfg_data <= hl;
		@(posedge clk);
		cfg_index <= CFG_NONE;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_q = thr;
		gap_lim_q = gl;
		hold_lim_q = hl;
		n_cfg++;
	endtask

	task automatic drain();
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// Compare one output transaction with the oldest expectation
	task automatic check_result(hold_res_t got);
		hold_res_t want;
		n_res++;
		if (got.ev == EV_POSE)
			n_poses++;
		if (pending_res.size() == 0) begin
			$error("unexpected result: event_res %0d", got.ev);
			n_err++;
			return;
		end
		want = pending_res.pop_front();
		if (got.ev !== want.ev) begin
			$error("event_res expected %0d actual %0d", want.ev, got.ev);
			n_err++;
		end
		if (got.mv !== want.mv) begin
			$error("is_moving expected %0d actual %0d", want.mv, got.mv);
			n_err++;
		end
		if (got.gl !== want.gl) begin
			$error("goal_on expected %0d actual %0d", want.gl, got.gl);
			n_err++;
		end
		for (int i = 0; i < POS_COUNT; i++) begin
			if (got.pos[i] !== want.pos[i]) begin
				$error("out_pos_%0d expected %0d actual %0d", i, pos_t'(want.pos[i]),
					pos_t'(got.pos[i]));
				n_err++;
			end
		end
	endtask

	// Output monitor
	always @(posedge clk) begin : mon
		hold_res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.ev = event_res;
			got.mv = is_moving;
			got.gl = goal_on;
			got.pos = {out_pos_7, out_pos_6, out_pos_5, out_pos_4,
				out_pos_3, out_pos_2, out_pos_1, out_pos_0};
			check_result(got);
		end
	end

	// Receiver: short random stalls, one long hold-off on request
	initial begin : rx
		int n;
		out_stall = 1'b0;
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				n = HOLD_OFF_CYC;
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				n = $urandom_range(1, 3);
			end else begin
				out_stall <= 1'b0;
				n = $urandom_range(1, 6);
			end
			repeat (n) @(posedge clk);
		end
	end

	// Main sequence
	initial begin : stim
		joint_item_t it;
		hold_res_t   none;
		int          n_dir;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SPEED;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_SAMPLE;
		stamp_us = '0;
		in_pos = '0;
		none = '0;

		// state after reset
		thr_q = SPEED_RST;
		gap_lim_q = GAP_RST;
		hold_lim_q = HOLD_RST;
		last_pos = '0;
		last_stamp = '0;
		arm_moving = 1'b1;
		goal_live = 1'b0;
		still_since = '0;

		// mode codes straight from reset; unused mode changes nothing
		add_row(MODE_PREEMPT, 40'd0, 20'sd0, NO_JOINT, 20'sd0, 1'b1, EV_PREEMPT, 1'b1, 1'b0);
		add_row(MODE_UNUSED, '1, POS_MIN, NO_JOINT, 20'sd0, 1'b1, EV_NONE, 1'b1, 1'b0);
		add_row(MODE_GOAL, 40'd0, 20'sd0, NO_JOINT, 20'sd0, 1'b1, EV_GOAL, 1'b1, 1'b1);
		add_row(MODE_GOAL, 40'd7, POS_MAX, NO_JOINT, 20'sd0, 1'b1, EV_GOAL, 1'b1, 1'b1);
		// still, then zero gap with a change, then zero gap without one
		add_row(MODE_SAMPLE, 40'd1000, 20'sd0, NO_JOINT, 20'sd0, 1'b1, EV_STILL, 1'b0, 1'b1);
		add_row(MODE_SAMPLE, 40'd1000, 20'sd0, 0, 20'sd1, 1'b1, EV_RESUME, 1'b1, 1'b1);
		add_row(MODE_SAMPLE, 40'd1000, 20'sd0, 0, 20'sd1, 1'b1, EV_STILL, 1'b0, 1'b1);
		// backwards in time, then a gap past the limit
		add_row(MODE_SAMPLE, 40'd500, POS_MAX, NO_JOINT, 20'sd0, 1'b0, EV_NONE, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 40'd2000000, POS_MAX, NO_JOINT, 20'sd0, 1'b0, EV_NONE, 1'b0,
			1'b0);
		// threshold boundary on the last joint: equal is still, one more moves
		add_row(MODE_SAMPLE, 40'd2015625, POS_MAX, 7, POS_MAX - 20'sd768, 1'b0, EV_NONE, 1'b0,
			1'b0);
		add_row(MODE_SAMPLE, 40'd2031250, POS_MAX, 7, POS_MAX - 20'sd1537, 1'b0, EV_NONE, 1'b0,
			1'b0);
		// hold: exactly at the limit, then one microsecond past it
		add_row(MODE_SAMPLE, 40'd2900000, POS_MAX, 7, POS_MAX - 20'sd1537, 1'b0, EV_NONE, 1'b0,
			1'b0);
		add_row(MODE_SAMPLE, 40'd3800000, POS_MAX, 7, POS_MAX - 20'sd1537, 1'b0, EV_NONE, 1'b0,
			1'b0);
		add_row(MODE_SAMPLE, 40'd4400000, POS_MAX, 7, POS_MAX - 20'sd1537, 1'b0, EV_NONE, 1'b0,
			1'b0);
		add_row(MODE_SAMPLE, 40'd4400001, POS_MAX, 7, POS_MAX - 20'sd1537, 1'b0, EV_NONE, 1'b0,
			1'b0);
		// top of the time range, then wrap back to zero
		add_row(MODE_SAMPLE, '1, POS_MIN, NO_JOINT, 20'sd0, 1'b0, EV_NONE, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 40'd0, POS_MIN, NO_JOINT, 20'sd0, 1'b0, EV_NONE, 1'b0, 1'b0);
		// hold start later than the sample time
		add_row(MODE_GOAL, 40'd0, 20'sd0, NO_JOINT, 20'sd0, 1'b0, EV_NONE, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 40'd100, POS_MIN, NO_JOINT, 20'sd0, 1'b0, EV_NONE, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 40'd50, POS_MIN, 3, POS_MAX, 1'b0, EV_NONE, 1'b0, 1'b0);
		add_row(MODE_PREEMPT, 40'd0, 20'sd0, NO_JOINT, 20'sd0, 1'b0, EV_NONE, 1'b0, 1'b0);
		add_row(MODE_SAMPLE, 40'd60, POS_MIN, 3, POS_MAX, 1'b0, EV_NONE, 1'b0, 1'b0);
		n_dir = dir_rows.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].want);
		in_valid <= 1'b0;

		// random phases, one register setting each
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			case (ph)
				0: load_regs(SPEED_RST, GAP_RST, HOLD_RST);
				1: load_regs(20'd0, 32'hFFFF_FFFF, 32'd0);
				2: load_regs(20'hFFFFF, 32'd5000, 32'd20000);
				3: load_regs(20'd1000, 32'd0, 32'd100);
				4: load_regs(20'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				default: load_regs(20'($urandom_range(1, 200000)),
					$urandom_range(1000, 3000000), $urandom_range(0, 4000000));
			endcase
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == 0 && k == 60)
					hold_req = 1'b1;
				if (ph == N_PHASES - 1 && k == ITEMS_PER_PHASE - CALM_ITEMS)
					calm = 1'b1;
				it = next_item();
				send_item(it, 1'b0, none);
			end
			in_valid <= 1'b0;
		end
		drain();

		$display("%0d transactions in (%0d from the table), %0d results checked",
			n_items, n_dir, n_res);
		$display("%0d pose reports over %0d register settings", n_poses, n_cfg);
		if (n_err == 0)
			$display("PASS joint_stillness_hold_detector");
		else
			$display("FAIL joint_stillness_hold_detector");
		$finish;
	end

endmodule
